>>> hw/rtl/mlui_pkg.sv
// ============================================================================
// mlui_pkg
// Shared defaults, loop phase and final-operation codes for the 4x4 LU
// inverter.
// ============================================================================
package mlui_pkg;

    // default configuration of the top level
    localparam int MATRIX_DIM_DEF = 4;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // active_size register
    localparam int               ASIZE_W   = 3;
    localparam logic [ASIZE_W-1:0] ASIZE_RST = 3'd4;

    // loop nest of the inversion, in execution order
    typedef enum logic [2:0] {
        PH_ROW0,    // first row of U divided by the first pivot
        PH_MID,     // Crout columns of L and rows of U
        PH_LINV,    // invert L
        PH_UINV,    // invert U
        PH_PROD     // inv(U) * inv(L)
    } ph_t;

    // how a finished dot product is written back
    typedef enum logic [2:0] {
        FIN_SUB,     // m[dst] - s
        FIN_SUBDIV,  // (m[dst] - s) / pivot
        FIN_DIV,     // s / pivot
        FIN_NEG,     // -s
        FIN_COPY     // s
    } fin_t;

endpackage

>>> hw/rtl/matrix_lu_inverse_4x4.sv
// Sequence: 16 input transactions, then the inversion, then the result elements one by one,
// each read from the store and held until taken. Each product term goes through the one
// shared multiplier/adder, each quotient through the bit-serial divider. Order 0 skips
// straight to output.
// Throughput: one matrix at a time; no input is taken until the last result is taken.
// Reset (aresetn, synchronous): control, counters and flags clear, active_size = 4;
// the matrix store is not cleared.
// ============================================================================
// matrix_lu_inverse_4x4
// Collects a matrix row-major, inverts its leading square by Crout LU without
// pivoting using one shared arithmetic unit, then streams the result out.
// ============================================================================
module matrix_lu_inverse_4x4 #(
    parameter int MATRIX_DIM = mlui_pkg::MATRIX_DIM_DEF,
    parameter int DATA_WIDTH = mlui_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mlui_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [mlui_pkg::ASIZE_W-1:0]       cfg_wdata,
    // input elements
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [DATA_WIDTH-1:0]       s_element_in,
    // result elements
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_element_out,
    output logic                               m_last_element,
    output logic                               m_divide_error,
    output logic                               m_saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int NUM = MATRIX_DIM * MATRIX_DIM;
    localparam int AW  = $clog2(NUM);
    localparam int KW  = $clog2(MATRIX_DIM + 1);
    localparam int QW  = DATA_WIDTH + FRAC_BITS;
    localparam int CW  = $clog2(QW + 1);

    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
    localparam bit                  ONE_CLIPS = (FRAC_BITS >= DATA_WIDTH - 1);
    localparam logic signed [W-1:0] ONE_VAL =
        ONE_CLIPS ? VAL_MAX : (W'(1) << FRAC_BITS);
    localparam logic [QW-1:0]       Q_POS_LIM = QW'(VAL_MAX);
    localparam logic [QW-1:0]       Q_NEG_LIM = QW'(1) << (W - 1);
    localparam logic [AW-1:0]       LAST_ADDR = AW'(NUM - 1);
    localparam logic [KW-1:0]       DIM_LAST  = KW'(MATRIX_DIM - 1);

    typedef enum logic [3:0] {
        ST_LOAD, ST_START, ST_SEL, ST_TERM, ST_RDB, ST_MUL, ST_SCALE, ST_ACC,
        ST_FIN, ST_DIVRD, ST_DIV, ST_DIVEND, ST_NEXT, ST_ORD, ST_OWAIT, ST_OHOLD
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] r,
                                              input logic [KW-1:0] c);
        addr_of = AW'(int'(r) * MATRIX_DIM + int'(c));
    endfunction

    state_t                     state_reg;
    logic [mlui_pkg::ASIZE_W-1:0] asize_reg;
    logic [KW-1:0]              n_reg;
    logic [AW-1:0]              load_cnt_reg;
    logic [AW-1:0]              out_cnt_reg;
    logic                       div_err_reg;
    logic                       sat_reg;
    mlui_pkg::ph_t              ph_reg;
    logic                       sub_reg;
    logic [KW-1:0]              i_reg;
    logic [KW-1:0]              j_reg;
    logic [KW-1:0]              k_reg;
    logic signed [W-1:0]        acc_reg;
    logic signed [W-1:0]        a_reg;
    logic signed [W-1:0]        term_reg;
    logic signed [W-1:0]        num_reg;
    logic signed [2*W-1:0]      prod_reg;
    logic [QW-1:0]              dvd_reg;
    logic [W-1:0]               rem_reg;
    logic [W-1:0]               dabs_reg;
    logic                       qneg_reg;
    logic [CW-1:0]              div_cnt_reg;
    logic                       m_valid_reg;
    logic                       m_last_reg;
    logic signed [W-1:0]        m_data_reg;

    // store
    logic signed [W-1:0]        mem [NUM];
    logic signed [W-1:0]        rd_q;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [W-1:0]        wr_data;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // descriptor of the current dot product and term
    // ------------------------------------------------------------------
    logic          d_valid, d_init_one, d_acc_sub, d_direct;
    logic [KW-1:0] d_k_lo, d_k_hi;
    logic [AW-1:0] d_a, d_b, d_dst, d_piv;
    mlui_pkg::fin_t d_fin;

    always_comb begin
        d_valid    = 1'b0;
        d_init_one = 1'b0;
        d_acc_sub  = 1'b0;
        d_direct   = 1'b0;
        d_k_lo     = '0;
        d_k_hi     = '0;
        d_a        = addr_of(j_reg, k_reg);
        d_b        = addr_of(k_reg, i_reg);
        d_dst      = addr_of(j_reg, i_reg);
        d_piv      = '0;
        d_fin      = mlui_pkg::FIN_COPY;
        unique case (ph_reg)
            mlui_pkg::PH_ROW0: begin
                d_valid = !sub_reg && (i_reg == '0) && (j_reg != '0) && (j_reg < n_reg);
                d_dst   = addr_of('0, j_reg);
                d_fin   = mlui_pkg::FIN_SUBDIV;
            end
            mlui_pkg::PH_MID: begin
                d_k_hi = i_reg;
                if (!sub_reg) begin
                    d_valid = (i_reg != '0) && (i_reg < n_reg) && (j_reg >= i_reg)
                              && (j_reg < n_reg);
                    d_fin   = mlui_pkg::FIN_SUB;
                end else begin
                    d_valid = (i_reg != '0) && ((i_reg + 1'b1) < n_reg)
                              && (j_reg > i_reg) && (j_reg < n_reg);
                    d_dst   = addr_of(i_reg, j_reg);
                    d_a     = addr_of(i_reg, k_reg);
                    d_b     = addr_of(k_reg, j_reg);
                    d_piv   = addr_of(i_reg, i_reg);
                    d_fin   = mlui_pkg::FIN_SUBDIV;
                end
            end
            mlui_pkg::PH_LINV: begin
                d_valid    = !sub_reg && (i_reg < n_reg) && (j_reg >= i_reg)
                             && (j_reg < n_reg);
                d_init_one = (i_reg == j_reg);
                d_acc_sub  = 1'b1;
                d_k_lo     = i_reg;
                d_k_hi     = j_reg;
                d_piv      = addr_of(j_reg, j_reg);
                d_fin      = mlui_pkg::FIN_DIV;
            end
            mlui_pkg::PH_UINV: begin
                d_valid  = !sub_reg && (i_reg < n_reg) && (j_reg > i_reg) && (j_reg < n_reg);
                d_k_lo   = i_reg;
                d_k_hi   = j_reg;
                d_direct = (k_reg == i_reg);
                d_dst    = addr_of(i_reg, j_reg);
                d_a      = addr_of(k_reg, j_reg);
                d_b      = addr_of(i_reg, k_reg);
                d_fin    = mlui_pkg::FIN_NEG;
            end
            mlui_pkg::PH_PROD: begin
                d_valid  = !sub_reg && (i_reg < n_reg) && (j_reg < n_reg);
                d_k_lo   = (i_reg > j_reg) ? i_reg : j_reg;
                d_k_hi   = n_reg;
                d_direct = (j_reg == k_reg);
                d_a      = d_direct ? addr_of(k_reg, i_reg) : addr_of(j_reg, k_reg);
                d_b      = addr_of(k_reg, i_reg);
                d_fin    = mlui_pkg::FIN_COPY;
            end
            default: d_valid = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // loop odometer: j innermost, then sub-pass, then i, then phase
    // ------------------------------------------------------------------
    mlui_pkg::ph_t nx_ph;
    logic          nx_sub, nx_done;
    logic [KW-1:0] nx_i, nx_j;

    always_comb begin
        nx_ph   = ph_reg;
        nx_sub  = sub_reg;
        nx_i    = i_reg;
        nx_j    = j_reg + 1'b1;
        nx_done = 1'b0;
        if (j_reg == DIM_LAST) begin
            nx_j = '0;
            if (ph_reg == mlui_pkg::PH_MID && !sub_reg) begin
                nx_sub = 1'b1;
            end else begin
                nx_sub = 1'b0;
                if (i_reg == DIM_LAST) begin
                    nx_i = '0;
                    unique case (ph_reg)
                        mlui_pkg::PH_ROW0: nx_ph = mlui_pkg::PH_MID;
                        mlui_pkg::PH_MID:  nx_ph = mlui_pkg::PH_LINV;
                        mlui_pkg::PH_LINV: nx_ph = mlui_pkg::PH_UINV;
                        mlui_pkg::PH_UINV: nx_ph = mlui_pkg::PH_PROD;
                        default:           nx_done = 1'b1;
                    endcase
                end else begin
                    nx_i = i_reg + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared saturating adder
    // ------------------------------------------------------------------
    logic signed [W-1:0] add_x, add_y, add_res;
    logic                add_sub, add_ovf;
    logic [W:0]          add_sum;

    always_comb begin
        add_x   = acc_reg;
        add_y   = term_reg;
        add_sub = d_acc_sub;
        if (state_reg == ST_FIN) begin
            add_sub = 1'b1;
            add_y   = acc_reg;
            add_x   = (d_fin == mlui_pkg::FIN_NEG) ? '0 : rd_q;
        end
        add_sum = add_sub ? ({add_x[W-1], add_x} - {add_y[W-1], add_y})
                          : ({add_x[W-1], add_x} + {add_y[W-1], add_y});
        add_ovf = add_sum[W] ^ add_sum[W-1];
        add_res = add_ovf ? (add_sum[W] ? VAL_MIN : VAL_MAX) : add_sum[W-1:0];
    end

    // product scaling: arithmetic shift is the floor, then clip
    logic signed [2*W-1:0] scaled;
    logic                  mul_hi, mul_lo;
    assign scaled = prod_reg >>> FRAC_BITS;
    assign mul_hi = scaled > (2*W)'(VAL_MAX);
    assign mul_lo = scaled < (2*W)'(VAL_MIN);

    // divider step and final sign/clip
    logic [W:0]          trial;
    logic                trial_ge;
    logic signed [W-1:0] div_res;
    logic                div_ovf;
    logic signed [W-1:0] zero_res;
    logic [W-1:0]        num_abs;

    assign trial    = {rem_reg, dvd_reg[QW-1]};
    assign trial_ge = trial >= {1'b0, dabs_reg};
    assign num_abs  = num_reg[W-1] ? W'(0 - num_reg) : W'(num_reg);
    assign zero_res = num_reg[W-1] ? VAL_MIN : VAL_MAX;

    always_comb begin
        if (qneg_reg) begin
            div_ovf = dvd_reg > Q_NEG_LIM;
            div_res = div_ovf ? VAL_MIN : W'(QW'(0) - dvd_reg);
        end else begin
            div_ovf = dvd_reg > Q_POS_LIM;
            div_res = div_ovf ? VAL_MAX : W'(dvd_reg);
        end
    end

    // ------------------------------------------------------------------
    // store ports
    // ------------------------------------------------------------------
    always_comb begin
        rd_addr = d_a;
        unique case (state_reg)
            ST_TERM: rd_addr = (k_reg == d_k_hi) ? d_dst : d_a;
            ST_RDB:  rd_addr = d_b;
            ST_FIN:  rd_addr = d_piv;
            ST_ORD:  rd_addr = out_cnt_reg;
            default: rd_addr = d_a;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = d_dst;
        wr_data = add_res;
        unique case (state_reg)
            ST_LOAD: begin
                wr_en   = s_fire;
                wr_addr = load_cnt_reg;
                wr_data = s_element_in;
            end
            ST_FIN: begin
                wr_en   = (d_fin == mlui_pkg::FIN_SUB) || (d_fin == mlui_pkg::FIN_NEG)
                          || (d_fin == mlui_pkg::FIN_COPY);
                wr_data = (d_fin == mlui_pkg::FIN_COPY) ? acc_reg : add_res;
            end
            ST_DIVRD: begin
                wr_en   = (rd_q == '0);
                wr_data = zero_res;
            end
            ST_DIVEND: begin
                wr_en   = 1'b1;
                wr_data = div_res;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            asize_reg    <= mlui_pkg::ASIZE_RST;
            n_reg        <= '0;
            load_cnt_reg <= '0;
            out_cnt_reg  <= '0;
            div_err_reg  <= 1'b0;
            sat_reg      <= 1'b0;
            ph_reg       <= mlui_pkg::PH_ROW0;
            sub_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            div_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                asize_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (load_cnt_reg == LAST_ADDR) begin
                            load_cnt_reg <= '0;
                            n_reg        <= (int'(asize_reg) > MATRIX_DIM) ?
                                            KW'(MATRIX_DIM) : KW'(asize_reg);
                            div_err_reg  <= 1'b0;
                            sat_reg      <= 1'b0;
                            state_reg    <= ST_START;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_START: begin
                    ph_reg  <= mlui_pkg::PH_ROW0;
                    sub_reg <= 1'b0;
                    i_reg   <= '0;
                    j_reg   <= '0;
                    if (n_reg == '0) begin
                        state_reg <= ST_ORD;
                    end else begin
                        sat_reg   <= ONE_CLIPS;
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL, ST_NEXT: begin
                    if (state_reg == ST_SEL && d_valid) begin
                        k_reg     <= d_k_lo;
                        acc_reg   <= d_init_one ? ONE_VAL : '0;
                        state_reg <= ST_TERM;
                    end else if (nx_done) begin
                        state_reg <= ST_ORD;
                    end else begin
                        ph_reg    <= nx_ph;
                        sub_reg   <= nx_sub;
                        i_reg     <= nx_i;
                        j_reg     <= nx_j;
                        state_reg <= ST_SEL;
                    end
                end
                ST_TERM: begin
                    state_reg <= (k_reg == d_k_hi) ? ST_FIN : ST_RDB;
                end
                ST_RDB: begin
                    a_reg    <= rd_q;
                    term_reg <= rd_q;
                    state_reg <= d_direct ? ST_ACC : ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= (2*W)'(a_reg) * (2*W)'(rd_q);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    term_reg  <= mul_hi ? VAL_MAX : (mul_lo ? VAL_MIN : W'(scaled));
                    sat_reg   <= sat_reg | mul_hi | mul_lo;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg   <= add_res;
                    sat_reg   <= sat_reg | add_ovf;
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= ST_TERM;
                end
                ST_FIN: begin
                    case (d_fin)
                        mlui_pkg::FIN_SUBDIV: begin
                            num_reg   <= add_res;
                            sat_reg   <= sat_reg | add_ovf;
                            state_reg <= ST_DIVRD;
                        end
                        mlui_pkg::FIN_DIV: begin
                            num_reg   <= acc_reg;
                            state_reg <= ST_DIVRD;
                        end
                        mlui_pkg::FIN_COPY: begin
                            state_reg <= ST_NEXT;
                        end
                        default: begin
                            sat_reg   <= sat_reg | add_ovf;
                            state_reg <= ST_NEXT;
                        end
                    endcase
                end
                ST_DIVRD: begin
                    if (rd_q == '0) begin
                        div_err_reg <= 1'b1;
                        sat_reg     <= 1'b1;
                        state_reg   <= ST_NEXT;
                    end else begin
                        dvd_reg     <= {num_abs, {FRAC_BITS{1'b0}}};
                        rem_reg     <= '0;
                        dabs_reg    <= rd_q[W-1] ? W'(0 - rd_q) : W'(rd_q);
                        qneg_reg    <= num_reg[W-1] ^ rd_q[W-1];
                        div_cnt_reg <= CW'(QW);
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg     <= trial_ge ? W'(trial - {1'b0, dabs_reg}) : W'(trial);
                    dvd_reg     <= {dvd_reg[QW-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == CW'(1)) begin
                        state_reg <= ST_DIVEND;
                    end
                end
                ST_DIVEND: begin
                    sat_reg   <= sat_reg | div_ovf;
                    state_reg <= ST_NEXT;
                end
                ST_ORD: begin
                    state_reg <= ST_OWAIT;
                end
                ST_OWAIT: begin
                    m_data_reg  <= rd_q;
                    m_valid_reg <= 1'b1;
                    m_last_reg  <= (out_cnt_reg == LAST_ADDR);
                    state_reg   <= ST_OHOLD;
                end
                ST_OHOLD: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            out_cnt_reg <= '0;
                            state_reg   <= ST_LOAD;
                        end else begin
                            out_cnt_reg <= out_cnt_reg + 1'b1;
                            state_reg   <= ST_ORD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_element_out  = m_data_reg;
    assign m_last_element = m_last_reg;
    assign m_divide_error = div_err_reg;
    assign m_saturated    = sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_element) |=> s_ready)
        else $error("input not reopened after final element");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_cnt_reg != '0))
        else $error("divider ran past its last step");

    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(n_reg) <= MATRIX_DIM))
        else $error("active order above matrix dimension");

    a_flags_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_divide_error) && $stable(m_saturated)))
        else $error("flags changed during output");

endmodule

>>> verif/matrix_lu_inverse_4x4_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// matrix_lu_inverse_4x4_tb
// Streams matrices into the LU inverter at a range of orders and checks every
// result element and flag against a fixed-point Crout LU predictor.
// ============================================================================
module matrix_lu_inverse_4x4_tb;

    localparam int DIM    = mlui_pkg::MATRIX_DIM_DEF;
    localparam int NELEM  = DIM * DIM;
    localparam int FRAC   = mlui_pkg::FRAC_BITS_DEF;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd1 <<< FRAC;

    // element-width copies for stimulus
    localparam logic signed [31:0] ONE_W  = 32'(ONE);
    localparam logic signed [31:0] VMAX_W = 32'(VMAX);
    localparam logic signed [31:0] VMIN_W = 32'(VMIN);

    // error flag bits
    localparam int FLAG_DIV = 0;
    localparam int FLAG_SAT = 1;

    // content styles of a generated matrix
    typedef enum int {
        MAT_DOMINANT,
        MAT_NOISE,
        MAT_SPARSE,
        MAT_EXTREME
    } mat_kind_t;

    typedef struct {
        logic signed [31:0] element;
        logic               last;
        logic               div_err;
        logic               sat;
    } result_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the inverse and checks the result stream
    // ------------------------------------------------------------------------
    class inverse_scoreboard;
        longint   store [NELEM];
        int       load_count;
        bit [1:0] flags;
        bit [2:0] order;
        result_t  pending [$];
        int       errors;

        function new();
            load_count = 0;
            flags      = '0;
            order      = mlui_pkg::ASIZE_RST;
            errors     = 0;
        endfunction

        function longint clip(longint v);
            if (v > VMAX) begin
                flags[FLAG_SAT] = 1'b1;
                return VMAX;
            end
            if (v < VMIN) begin
                flags[FLAG_SAT] = 1'b1;
                return VMIN;
            end
            return v;
        endfunction

        // product floored by the fraction bits
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            if (p >= 0)
                return clip(p >>> FRAC);
            return clip(-(((-p) + ONE - 1) >>> FRAC));
        endfunction

        // quotient truncated toward zero; zero divisor saturates by sign
        function longint fdiv(longint n, longint d);
            if (d == 0) begin
                flags[FLAG_DIV] = 1'b1;
                flags[FLAG_SAT] = 1'b1;
                return (n >= 0) ? VMAX : VMIN;
            end
            return clip((n * ONE) / d);
        endfunction

        function void invert(int n);
            longint s, x, t;
            for (int i = 1; i < n; i++)
                store[i] = fdiv(store[i], store[0]);
            // Crout: column i of L, then row i of U
            for (int i = 1; i < n; i++) begin
                for (int j = i; j < n; j++) begin
                    s = 0;
                    for (int k = 0; k < i; k++)
                        s = clip(s + fmul(store[j*DIM+k], store[k*DIM+i]));
                    store[j*DIM+i] = clip(store[j*DIM+i] - s);
                end
                if (i != n - 1) begin
                    for (int j = i + 1; j < n; j++) begin
                        s = 0;
                        for (int k = 0; k < i; k++)
                            s = clip(s + fmul(store[i*DIM+k], store[k*DIM+j]));
                        store[i*DIM+j] = fdiv(clip(store[i*DIM+j] - s), store[i*DIM+i]);
                    end
                end
            end
            // invert L
            for (int i = 0; i < n; i++)
                for (int j = i; j < n; j++) begin
                    x = ONE;
                    if (i != j) begin
                        x = 0;
                        for (int k = i; k < j; k++)
                            x = clip(x - fmul(store[j*DIM+k], store[k*DIM+i]));
                    end
                    store[j*DIM+i] = fdiv(x, store[j*DIM+j]);
                end
            // invert U (unit diagonal)
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++) begin
                    s = 0;
                    for (int k = i; k < j; k++) begin
                        t = (i == k) ? store[k*DIM+j]
                                     : fmul(store[k*DIM+j], store[i*DIM+k]);
                        s = clip(s + t);
                    end
                    store[i*DIM+j] = clip(-s);
                end
            // inv(U) * inv(L)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    s = 0;
                    for (int k = (i > j) ? i : j; k < n; k++) begin
                        t = (j == k) ? store[k*DIM+i]
                                     : fmul(store[j*DIM+k], store[k*DIM+i]);
                        s = clip(s + t);
                    end
                    store[j*DIM+i] = s;
                end
        endfunction

        // accepted input transaction
        function void note_input(logic signed [31:0] v);
            int      n;
            result_t r;
            store[load_count] = v;
            load_count++;
            if (load_count < NELEM)
                return;
            load_count = 0;
            flags = '0;
            n = (order > DIM) ? DIM : order;
            if (n > 0)
                invert(n);
            for (int e = 0; e < NELEM; e++) begin
                r.element = store[e][31:0];
                r.last    = (e == NELEM - 1);
                r.div_err = flags[FLAG_DIV];
                r.sat     = flags[FLAG_SAT];
                pending.push_back(r);
            end
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $time, what);
            errors++;
        endtask

        // accepted output transaction
        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected element %h", got.element));
                return;
            end
            want = pending.pop_front();
            if (got.element !== want.element)
                report($sformatf("element %h, expected %h", got.element, want.element));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
            if (got.div_err !== want.div_err)
                report($sformatf("divide_error %b, expected %b", got.div_err, want.div_err));
            if (got.sat !== want.sat)
                report($sformatf("saturated %b, expected %b", got.sat, want.sat));
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_element_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_element_out;
    logic               m_last_element;
    logic               m_divide_error;
    logic               m_saturated;

    inverse_scoreboard sb = new();

    matrix_lu_inverse_4x4 uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_in   (s_element_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_element_out  (m_element_out),
        .m_last_element (m_last_element),
        .m_divide_error (m_divide_error),
        .m_saturated    (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, occasionally long ones, often none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: sample the handshake, then pick the next ready
    initial begin
        result_t got;
        int      stall;
        m_ready = 1'b0;
        stall   = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.element = m_element_out;
                got.last    = m_last_element;
                got.div_err = m_divide_error;
                got.sat     = m_saturated;
                sb.check_result(got);
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_ready <= (stall == 0);
            end
        end
    end

    task automatic send_element(logic signed [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_element_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(v);
    endtask

    // written only with the block idle
    task automatic write_order(logic [2:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.order = v;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] make_element(mat_kind_t kind, int r, int c);
        logic signed [31:0] v;
        case (kind)
            MAT_DOMINANT: begin
                if (r == c) begin
                    v = $urandom_range(ONE_W / 2, 8 * ONE_W);
                    if ($urandom_range(0, 1)) v = -v;
                end else begin
                    v = $signed($urandom_range(0, ONE_W)) - (ONE_W / 2);
                end
            end
            MAT_NOISE:  v = $urandom;
            MAT_SPARSE: v = ($urandom_range(0, 2) == 0) ? 32'sd0
                          : $signed($urandom_range(0, 4 * ONE_W)) - 2 * ONE_W;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = VMAX_W;
                    1:       v = VMIN_W;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_matrix(mat_kind_t kind);
        for (int e = 0; e < NELEM; e++)
            send_element(make_element(kind, e / DIM, e % DIM));
    endtask

    // stimulus
    initial begin
        logic [2:0] ord;
        int         pick;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_element_in = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity at full order: result equals input
        write_order(3'd4);
        for (int e = 0; e < NELEM; e++)
            send_element((e / DIM == e % DIM) ? ONE_W : 32'sd0);
        wait_drained();

        // zero first pivot at order 2; extremes outside the square pass through
        write_order(3'd2);
        for (int e = 0; e < NELEM; e++)
            send_element((e / DIM < 2 && e % DIM < 2) ? ((e == 0) ? 32'sd0 : ONE_W)
                         : ((e % 2) ? VMAX_W : VMIN_W));
        wait_drained();

        // random matrices over every register value
        for (int m = 0; m < 15; m++) begin
            ord = (m < 8) ? m[2:0] : 3'($urandom_range(1, 4));
            write_order(ord);
            pick = $urandom_range(0, 9);
            if (pick < 6)      send_matrix(MAT_DOMINANT);
            else if (pick < 8) send_matrix(MAT_NOISE);
            else if (pick < 9) send_matrix(MAT_SPARSE);
            else               send_matrix(MAT_EXTREME);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
